[sv/lgc_pkg.sv]
// Shared types and constants of the lamp group controller.
package lgc_pkg;

	localparam int LAMP_SLOTS = 4;

	// Register indexes on the configuration port
	typedef enum logic [0:0] {
		CFG_HOLD_TICKS = 1'b0,
		CFG_OFF_LEVEL  = 1'b1
	} cfg_idx_t;

	localparam logic [15:0] HOLD_TICKS_RST = 16'd4000;
	localparam logic        OFF_LEVEL_RST  = 1'b1;
	localparam logic [3:0]  CHECK_HIGH     = 4'hF;

	typedef struct packed {
		logic [7:0] command_byte;
		logic       command_valid;
		logic [3:0] photo_sense;
		logic [3:0] ir_sense;
		logic [1:0] ambient_sense;
		logic [3:0] alarm_lines_n;
	} pass_item_t;

	typedef struct packed {
		logic [7:0] check_byte;
		logic [3:0] alarm_report;
		logic       alarm_report_valid;
		logic [3:0] lamp_outputs;
		logic [3:0] mode_outputs;
		logic       buzzer_level;
	} pass_result_t;

endpackage

[sv/lamp_group_controller.sv]
// Lamp group controller: alarm hold counters, lamp mode and switch drive, lamp check.
//
// Pipeline: an accepted item is registered in the input stage, and its result is
// loaded into the result register and shown on m_tvalid when that stage advances.
// Throughput: one item per cycle unless output backpressure stalls; hold counters and
// lamp flags update on advance, so each pass sees the state the previous pass left.
// Reset (arst_n low, asynchronous): counters cleared, lamp flags and drive levels all
// ones, hold_ticks = 4000, off_level = 1, both pipeline stages empty.
module lamp_group_controller
	import lgc_pkg::*;
#(
	parameter int NUM_LAMPS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_wen,
	input  logic [0:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	// Input items, one per control pass
	input  logic        s_tvalid,
	output logic        s_tready,
	// [3:0] alarm_lines_n, [5:4] ambient_sense, [9:6] ir_sense,
	// [13:10] photo_sense, [21:14] command_byte, [23:22] zero
	input  logic [23:0] s_tdata,
	// [0] command_valid
	input  logic [0:0]  s_tuser,
	// Result items
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] buzzer_level, [4:1] mode_outputs, [8:5] lamp_outputs,
	// [12:9] alarm_report, [20:13] check_byte, [23:21] zero
	output logic [23:0] m_tdata,
	// [0] alarm_report_valid
	output logic [0:0]  m_tuser
);

	// Configuration registers
	logic [15:0] hold_ticks_q;
	logic        off_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= HOLD_TICKS_RST;
			off_level_q  <= OFF_LEVEL_RST;
		end else if (cfg_wen) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_HOLD_TICKS: hold_ticks_q <= cfg_wdata;
				CFG_OFF_LEVEL:  off_level_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Input stage
	logic       valid_s1;
	pass_item_t item_s1;
	logic       advance;

	// Result register
	logic         out_valid_q;
	pass_result_t out_q;

	// Advance the input stage whenever the result register is free or being drained;
	// ready only drops under real backpressure from the output side.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= pass_item_t'({s_tdata[21:14], s_tuser[0], s_tdata[13:0]});
		end
	end

	// Control state
	logic [15:0]           hold_q [NUM_LAMPS];
	logic [LAMP_SLOTS-1:0] auto_q;
	logic [LAMP_SLOTS-1:0] manual_on_q;
	logic [LAMP_SLOTS-1:0] lamp_drive_q;
	logic [LAMP_SLOTS-1:0] mode_drive_q;

	logic [15:0]           hold_nxt [NUM_LAMPS];
	logic [LAMP_SLOTS-1:0] auto_nxt;
	logic [LAMP_SLOTS-1:0] manual_on_nxt;
	logic [LAMP_SLOTS-1:0] lamp_drive_nxt;
	logic [LAMP_SLOTS-1:0] mode_drive_nxt;
	pass_result_t          res;

	// One control pass: counters, lamp refresh and check byte, all lamps side by side
	always_comb begin
		logic                  any_before;
		logic                  any_loaded;
		logic                  daylight;
		logic                  hit;
		logic                  refresh;
		logic                  fault;
		logic [1:0]            cmd_idx;
		logic [15:0]           loaded [NUM_LAMPS];
		logic [LAMP_SLOTS-1:0] report;
		logic [LAMP_SLOTS-1:0] healthy;

		any_before     = 1'b0;
		any_loaded     = 1'b0;
		hit            = 1'b0;
		refresh        = 1'b0;
		fault          = 1'b0;
		daylight       = (item_s1.ambient_sense == 2'b00);
		cmd_idx        = item_s1.command_byte[7:6];
		report         = '0;
		healthy        = '1;
		auto_nxt       = auto_q;
		manual_on_nxt  = manual_on_q;
		lamp_drive_nxt = lamp_drive_q;
		mode_drive_nxt = mode_drive_q;

		// Buzzer looks at the counters before this pass; an active line reloads its counter
		for (int k = 0; k < NUM_LAMPS; k++) begin
			if (hold_q[k] != 16'd0) any_before = 1'b1;
			loaded[k] = item_s1.alarm_lines_n[k] ? hold_q[k] : hold_ticks_q;
			if (loaded[k] != 16'd0) any_loaded = 1'b1;
		end

		// Count down and report whatever is still held
		for (int k = 0; k < NUM_LAMPS; k++) begin
			hold_nxt[k] = (loaded[k] != 16'd0) ? loaded[k] - 16'd1 : 16'd0;
			report[k]   = any_loaded && (hold_nxt[k] != 16'd0);
		end

		for (int k = 0; k < LAMP_SLOTS; k++) begin
			if (k < NUM_LAMPS) begin
				// A command touches only its addressed lamp; without one every lamp refreshes
				hit     = item_s1.command_valid && (cmd_idx == 2'(k));
				refresh = hit || !item_s1.command_valid;
				if (hit) begin
					auto_nxt[k] = item_s1.command_byte[1];
					if (!item_s1.command_byte[1]) begin
						manual_on_nxt[k] = !item_s1.command_byte[0];
					end
				end
				if (refresh) begin
					if (auto_nxt[k]) begin
						mode_drive_nxt[k] = !daylight;
						if (daylight) lamp_drive_nxt[k] = off_level_q;
					end else begin
						mode_drive_nxt[k] = 1'b0;
						lamp_drive_nxt[k] = manual_on_nxt[k];
					end
				end
				// Suspect a lamp that is lit while switched off, or lit with no infrared
				fault = item_s1.photo_sense[k] &&
					((!auto_nxt[k] && !manual_on_nxt[k]) || !item_s1.ir_sense[k]);
				healthy[k] = !fault;
			end
		end

		res.buzzer_level       = !any_before;
		res.mode_outputs       = mode_drive_nxt;
		res.lamp_outputs       = lamp_drive_nxt;
		res.alarm_report_valid = any_loaded;
		res.alarm_report       = report;
		res.check_byte         = {CHECK_HIGH, healthy};
	end

	// Commit the pass to the state as the item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_LAMPS; k++) hold_q[k] <= '0;
			auto_q       <= '1;
			manual_on_q  <= '1;
			lamp_drive_q <= '1;
			mode_drive_q <= '1;
		end else if (advance) begin
			for (int k = 0; k < NUM_LAMPS; k++) hold_q[k] <= hold_nxt[k];
			auto_q       <= auto_nxt;
			manual_on_q  <= manual_on_nxt;
			lamp_drive_q <= lamp_drive_nxt;
			mode_drive_q <= mode_drive_nxt;
		end
	end

	// Result register: load on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.alarm_report_valid;
	assign m_tdata  = {3'b000, out_q.check_byte, out_q.alarm_report, out_q.lamp_outputs,
		out_q.mode_outputs, out_q.buzzer_level};

	// Checks
	localparam logic [LAMP_SLOTS-1:0] PRESENT = LAMP_SLOTS'((1 << NUM_LAMPS) - 1);

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stage stalled without output backpressure");

	a_advance_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("advanced item produced no result");

	a_report_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata[12:9] == 4'd0))
		else $error("alarm bitmap set without a valid mark");

	a_absent_lamps_held: assert property (@(posedge clk) disable iff (!arst_n)
		((lamp_drive_q | PRESENT) == '1) && ((mode_drive_q | PRESENT) == '1))
		else $error("drive bit of an absent lamp changed");

endmodule

[tb/lamp_group_controller_tb.sv]
// Self-checking testbench for the lamp group controller: directed and random passes.
`timescale 1ns / 1ps

module lamp_group_controller_tb;
	import lgc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	cfg_idx_t    cfg_addr;
	logic [15:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	// [3:0] alarm_lines_n, [5:4] ambient_sense, [9:6] ir_sense,
	// [13:10] photo_sense, [21:14] command_byte, [23:22] zero
	logic [23:0] s_tdata;
	// [0] command_valid
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [0] buzzer_level, [4:1] mode_outputs, [8:5] lamp_outputs,
	// [12:9] alarm_report, [20:13] check_byte, [23:21] zero
	logic [23:0] m_tdata;
	// [0] alarm_report_valid
	logic [0:0]  m_tuser;

	lamp_group_controller dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Controller state as the predictor sees it; starts at the reset values
	logic [15:0] lamp_hold [LAMP_SLOTS] = '{default: 16'd0};
	logic [3:0]  lamp_auto      = 4'hF;
	logic [3:0]  lamp_manual_on = 4'hF;
	logic [3:0]  switch_drive   = 4'hF;
	logic [3:0]  mode_drive     = 4'hF;
	logic [15:0] model_hold_ticks = HOLD_TICKS_RST;
	logic        model_off_level  = OFF_LEVEL_RST;

	pass_result_t pending_results [$];
	int mismatch_count = 0;

	// Idling controls, changed per phase
	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int holdoff_left       = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Limit on the whole run, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// Drive one lamp from its flags: automatic lamps follow the ambient light,
	// manual lamps follow their manual switch flag.
	function automatic void refresh_lamp(int k, logic daylight);
		if (lamp_auto[k]) begin
			if (daylight) begin
				mode_drive[k]   = 1'b0;
				switch_drive[k] = model_off_level;
			end else begin
				mode_drive[k] = 1'b1;
			end
		end else begin
			mode_drive[k]   = 1'b0;
			switch_drive[k] = lamp_manual_on[k];
		end
	endfunction

	// Work out the result of one control pass and advance the state copy.
	function automatic pass_result_t compute_pass(pass_item_t it);
		pass_result_t r;
		logic         any_hold;
		logic         daylight;
		logic [1:0]   lamp;
		logic         fault;
		r = '0;
		// buzzer comes from the counters as they stood before this pass
		any_hold = 1'b0;
		for (int k = 0; k < LAMP_SLOTS; k++)
			if (lamp_hold[k] != 16'd0)
				any_hold = 1'b1;
		r.buzzer_level = !any_hold;
		// reload the counters of active (low) alarm lines
		for (int k = 0; k < LAMP_SLOTS; k++)
			if (!it.alarm_lines_n[k])
				lamp_hold[k] = model_hold_ticks;
		any_hold = 1'b0;
		for (int k = 0; k < LAMP_SLOTS; k++)
			if (lamp_hold[k] != 16'd0)
				any_hold = 1'b1;
		r.alarm_report_valid = any_hold;
		if (any_hold) begin
			for (int k = 0; k < LAMP_SLOTS; k++) begin
				if (lamp_hold[k] != 16'd0)
					lamp_hold[k] = lamp_hold[k] - 16'd1;
				r.alarm_report[k] = (lamp_hold[k] != 16'd0);
			end
		end
		daylight = (it.ambient_sense == 2'b00);
		// a command touches only its lamp; without one every lamp is refreshed
		if (it.command_valid) begin
			lamp = it.command_byte[7:6];
			lamp_auto[lamp] = it.command_byte[1];
			if (!lamp_auto[lamp])
				lamp_manual_on[lamp] = !it.command_byte[0];
			refresh_lamp(int'(lamp), daylight);
		end else begin
			for (int k = 0; k < LAMP_SLOTS; k++)
				refresh_lamp(k, daylight);
		end
		// suspect a lamp that is lit while switched off, or lit with no infrared
		for (int k = 0; k < LAMP_SLOTS; k++) begin
			fault = (!lamp_auto[k] && !lamp_manual_on[k] && it.photo_sense[k]) ||
				(!it.ir_sense[k] && it.photo_sense[k]);
			r.check_byte[k] = !fault;
		end
		r.check_byte[7:4] = CHECK_HIGH;
		r.mode_outputs = mode_drive;
		r.lamp_outputs = switch_drive;
		return r;
	endfunction

	function automatic void check_field(string field, int want, int got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatch_count++;
		end
	endfunction

	// Predict on every accepted pass, check every accepted result against the oldest
	always @(posedge clk) begin : result_monitor
		pass_item_t   taken;
		pass_result_t want;
		if (s_tvalid && s_tready) begin
			taken.alarm_lines_n = s_tdata[3:0];
			taken.ambient_sense = s_tdata[5:4];
			taken.ir_sense      = s_tdata[9:6];
			taken.photo_sense   = s_tdata[13:10];
			taken.command_byte  = s_tdata[21:14];
			taken.command_valid = s_tuser[0];
			pending_results.push_back(compute_pass(taken));
		end
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result item arrived with no pass pending");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("buzzer_level", int'(want.buzzer_level), int'(m_tdata[0]));
				check_field("mode_outputs", int'(want.mode_outputs), int'(m_tdata[4:1]));
				check_field("lamp_outputs", int'(want.lamp_outputs), int'(m_tdata[8:5]));
				check_field("alarm_report", int'(want.alarm_report), int'(m_tdata[12:9]));
				check_field("check_byte", int'(want.check_byte), int'(m_tdata[20:13]));
				check_field("alarm_report_valid", int'(want.alarm_report_valid),
					int'(m_tuser[0]));
			end
		end
	end

	// Receiver: hold off for a requested stretch, otherwise stall at random
	initial begin
		forever begin
			@(negedge clk);
			if (holdoff_left > 0) begin
				m_tready <= 1'b0;
				holdoff_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	// Offer one pass; entered and left at a falling edge, valid left high
	task automatic send_pass(input pass_item_t it);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata  <= {2'b00, it.command_byte, it.photo_sense, it.ir_sense,
			it.ambient_sense, it.alarm_lines_n};
		s_tuser  <= it.command_valid;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Drop valid and wait until every pending result has come out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [15:0] value);
		drain_results();
		cfg_wen   <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		case (idx)
			CFG_HOLD_TICKS: model_hold_ticks = value;
			CFG_OFF_LEVEL:  model_off_level  = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	function automatic pass_item_t make_pass(logic [3:0] alarm_n, logic [1:0] ambient,
		logic [3:0] ir, logic [3:0] photo, logic cmd_valid, logic [7:0] cmd);
		pass_item_t it;
		it.alarm_lines_n = alarm_n;
		it.ambient_sense = ambient;
		it.ir_sense      = ir;
		it.photo_sense   = photo;
		it.command_valid = cmd_valid;
		it.command_byte  = cmd;
		return it;
	endfunction

	// Mostly quiet alarm lines so counters run down; commands on about 40 % of passes
	function automatic pass_item_t random_pass();
		logic [3:0] alarm_n;
		alarm_n = ($urandom_range(99) < 85) ? 4'hF : 4'($urandom_range(15));
		return make_pass(alarm_n, 2'($urandom_range(3)), 4'($urandom_range(15)),
			4'($urandom_range(15)), ($urandom_range(99) < 40), 8'($urandom_range(255)));
	endfunction

	// Reset state, every command kind, faults and the hold counter extremes
	task automatic test_directed();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		send_pass(make_pass(4'hF, 2'b01, 4'hF, 4'h0, 1'b0, 8'h00)); // night, reset drives
		send_pass(make_pass(4'hF, 2'b00, 4'hF, 4'h0, 1'b0, 8'h00)); // daylight, lamps off
		send_pass(make_pass(4'hF, 2'b11, 4'h0, 4'hF, 1'b0, 8'h00)); // lit without infrared
		send_pass(make_pass(4'hF, 2'b10, 4'hF, 4'h0, 1'b1, 8'h00)); // lamp 0 manual on
		send_pass(make_pass(4'hF, 2'b10, 4'hF, 4'hF, 1'b1, 8'h41)); // lamp 1 manual off, lit
		send_pass(make_pass(4'hF, 2'b01, 4'hF, 4'h0, 1'b1, 8'h82)); // lamp 2 automatic
		send_pass(make_pass(4'hF, 2'b00, 4'hF, 4'h0, 1'b1, 8'hC2)); // lamp 3 automatic, day
		send_pass(make_pass(4'hF, 2'b11, 4'h0, 4'hF, 1'b1, 8'hFD)); // lamp 3 manual off
		send_pass(make_pass(4'hF, 2'b11, 4'hF, 4'hF, 1'b0, 8'hFF)); // byte ignored
		send_pass(make_pass(4'hE, 2'b01, 4'hF, 4'h0, 1'b0, 8'h00)); // alarm on lamp 0
		send_pass(make_pass(4'hF, 2'b01, 4'hF, 4'h0, 1'b0, 8'h00)); // buzzer sounds
		send_pass(make_pass(4'h0, 2'b01, 4'hF, 4'h0, 1'b0, 8'h00)); // every alarm
		// one-pass hold on lamp 3: its reloaded counter runs out at once and is not reported
		write_register(CFG_HOLD_TICKS, 16'd1);
		send_pass(make_pass(4'h7, 2'b01, 4'hF, 4'h0, 1'b0, 8'h00));
		send_pass(make_pass(4'hF, 2'b01, 4'hF, 4'h0, 1'b0, 8'h00));
		// zero hold: an active line is never reported
		write_register(CFG_HOLD_TICKS, 16'd0);
		send_pass(make_pass(4'h0, 2'b01, 4'hF, 4'h0, 1'b0, 8'h00));
		send_pass(make_pass(4'hF, 2'b01, 4'hF, 4'h0, 1'b0, 8'h00));
		// switch-off level low in daylight
		write_register(CFG_OFF_LEVEL, 16'd0);
		send_pass(make_pass(4'hF, 2'b00, 4'hF, 4'h0, 1'b1, 8'h02));
		send_pass(make_pass(4'hF, 2'b00, 4'hF, 4'h0, 1'b0, 8'h00));
		write_register(CFG_HOLD_TICKS, 16'hFFFF);
		send_pass(make_pass(4'hB, 2'b01, 4'hF, 4'h0, 1'b0, 8'h00));
		send_pass(make_pass(4'hF, 2'b10, 4'hF, 4'h0, 1'b0, 8'h00));
	endtask

	task automatic test_random_phase(input int count, input int idle_pct, input int stall_pct);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		repeat (count)
			send_pass(random_pass());
	endtask

	// Hold the receiver off for a long stretch so the block fills and stalls its input
	task automatic test_backpressure();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		holdoff_left       = 300;
		repeat (60)
			send_pass(random_pass());
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_wen   = 1'b0;
		cfg_addr  = CFG_HOLD_TICKS;
		cfg_wdata = 16'd0;
		s_tvalid  = 1'b0;
		s_tdata   = 24'd0;
		s_tuser   = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();

		write_register(CFG_HOLD_TICKS, 16'd3);
		write_register(CFG_OFF_LEVEL, 16'd1);
		test_random_phase(400, 0, 0);

		write_register(CFG_HOLD_TICKS, 16'd17);
		write_register(CFG_OFF_LEVEL, 16'd0);
		test_random_phase(400, 74, 0);

		write_register(CFG_HOLD_TICKS, 16'($urandom_range(1, 40)));
		write_register(CFG_OFF_LEVEL, 16'd1);
		test_random_phase(400, 0, 74);

		write_register(CFG_HOLD_TICKS, 16'($urandom_range(2, 200)));
		write_register(CFG_OFF_LEVEL, 16'd0);
		test_random_phase(400, 21, 21);

		write_register(CFG_HOLD_TICKS, 16'd5);
		test_backpressure();

		// extremes of the hold count under random traffic
		write_register(CFG_HOLD_TICKS, 16'hFFFF);
		test_random_phase(50, 21, 21);
		write_register(CFG_HOLD_TICKS, 16'd1);
		test_random_phase(50, 0, 0);

		drain_results();
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[sim.f]
sv/lgc_pkg.sv
sv/lamp_group_controller.sv
tb/lamp_group_controller_tb.sv
